// ===== rtl/shamh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package shamh_pkg;

    // Width of the running message length counter, 32 to 64 bits.
    localparam int LEN_BITS = 64;

    localparam int WORD_BITS  = 32;
    localparam int NUM_CHAIN  = 8;
    localparam int NUM_ROUNDS = 64;

    // Byte positions in a 64-byte block.
    localparam logic [5:0] SLOT_LAST = 6'd63;
    localparam logic [5:0] SLOT_LEN  = 6'd56;

    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef logic [WORD_BITS-1:0] t_word;

    // Working variables a..h, index 0 holds a.
    typedef logic [NUM_CHAIN-1:0][WORD_BITS-1:0] t_vars;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_FOLD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       push;
        logic       word_done;
        logic [7:0] byte_val;
        logic       round_shift;
    } t_sched_ctrl;

    localparam logic [0:NUM_CHAIN-1][WORD_BITS-1:0] IV_WORDS = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:NUM_ROUNDS-1][WORD_BITS-1:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (WORD_BITS - n));
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/shamh_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface shamh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       has_byte;
    logic       is_last;

    modport source (output valid, output byte_value, output has_byte, output is_last,
                    input ready);
    modport sink (input valid, input byte_value, input has_byte, input is_last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/shamh_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface shamh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/shamh_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module shamh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/shamh_sched.sv =====
`timescale 1ns / 1ps
`default_nettype none

module shamh_sched (
    input  wire logic                  i_clk,
    input  wire shamh_pkg::t_sched_ctrl i_ctrl,
    output shamh_pkg::t_word           o_w
);

    logic [23:0]      r_acc;
    shamh_pkg::t_word r_w [16];
    shamh_pkg::t_word w_next;

    // Window holds W[t]..W[t+15]; this forms W[t+16].
    assign w_next = r_w[0] + shamh_pkg::small_sigma0(r_w[1]) + r_w[9]
                  + shamh_pkg::small_sigma1(r_w[14]);
    assign o_w = r_w[0];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_acc <= {r_acc[15:0], i_ctrl.byte_val};
        end
        if (i_ctrl.push && i_ctrl.word_done) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= {r_acc, i_ctrl.byte_val};
        end else if (i_ctrl.round_shift) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/shamh_round.sv =====
`timescale 1ns / 1ps
`default_nettype none

module shamh_round (
    input  wire shamh_pkg::t_vars i_vars,
    input  wire shamh_pkg::t_word i_k,
    input  wire shamh_pkg::t_word i_w,
    output shamh_pkg::t_vars      o_vars
);

    shamh_pkg::t_word t1;
    shamh_pkg::t_word t2;
    shamh_pkg::t_word ch;
    shamh_pkg::t_word maj;

    always_comb begin
        ch  = (i_vars[4] & i_vars[5]) ^ (~i_vars[4] & i_vars[6]);
        maj = (i_vars[0] & i_vars[1]) ^ (i_vars[0] & i_vars[2]) ^ (i_vars[1] & i_vars[2]);
        t1  = i_vars[7] + shamh_pkg::big_sigma1(i_vars[4]) + ch + i_k + i_w;
        t2  = shamh_pkg::big_sigma0(i_vars[0]) + maj;
        o_vars[7] = i_vars[6];
        o_vars[6] = i_vars[5];
        o_vars[5] = i_vars[4];
        o_vars[4] = i_vars[3] + t1;
        o_vars[3] = i_vars[2];
        o_vars[2] = i_vars[1];
        o_vars[1] = i_vars[0];
        o_vars[0] = t1 + t2;
    end

endmodule

`default_nettype wire

// ===== rtl/sha256_message_hasher.sv =====
`timescale 1ns / 1ps
`default_nettype none

// SHA-256 hasher that takes a message one byte per transfer.
// Input channel i_in: byte_value with has_byte set adds a byte to the message;
// is_last ends the message (with or without a byte in the same transfer).
// Output channel o_out: eight transfers of digest_word, word_index 0..7,
// last_word set on the eighth. The chaining value then returns to the IV.
// A byte that does not fill a block leaves the input ready for the next. The 64th byte of a
// block starts a compression: the chaining words are read from the chain RAM,
// 64 rounds run on one shared round unit, and the result is added back
// through the RAM's single read and write ports. No byte is taken while a
// block is compressed. After is_last, padding bytes are generated one per cycle
// (up to 72), followed by one or two compressions, then the digest is held in
// an output register and shifted out, one word per output transfer.
// No input is taken from is_last until the last digest word is transferred;
// when the receiver stalls, the current word is held.
// Reset (synchronous, active low) clears the length count, block position and
// the chain RAM valid bits, so the chaining value reads as the IV at once.

module sha256_message_hasher (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    shamh_in_if.sink   i_in,
    shamh_out_if.source o_out
);

    shamh_pkg::t_state r_state;
    shamh_pkg::t_state n_state;

    logic [5:0]                    r_cnt;
    logic [5:0]                    r_slot;
    logic [shamh_pkg::LEN_BITS-1:0] r_bit_len;
    shamh_pkg::t_vars              r_vars;
    logic [7:0]                    r_chain_vld;
    logic                          r_marked;
    logic                          r_len_ok;
    logic                          r_padding;
    logic                          r_final;
    logic [2:0]                    r_oidx;
    logic [2:0]                    r_rd_addr;
    logic                          r_rd_iv;

    logic                  in_fire;
    logic                  out_fire;
    logic                  push_en;
    logic [7:0]            push_byte;
    logic                  wrap;
    logic                  start_pad;
    logic                  set_final;
    logic                  count_len;
    logic [2:0]            raddr;
    logic                  we;
    logic [2:0]            waddr;
    logic [63:0]           len64;
    logic [7:0]            len_byte;
    shamh_pkg::t_word      ram_q;
    shamh_pkg::t_word      rd_word;
    shamh_pkg::t_word      fold_sum;
    shamh_pkg::t_word      w_cur;
    shamh_pkg::t_vars      round_vars;
    shamh_pkg::t_sched_ctrl sched_ctrl;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign len64    = 64'(r_bit_len);
    assign len_byte = 8'(len64 >> {~r_slot[2:0], 3'b000});
    assign rd_word  = r_rd_iv ? shamh_pkg::IV_WORDS[r_rd_addr] : ram_q;
    assign fold_sum = rd_word + r_vars[0];
    assign waddr    = r_cnt[2:0] - 3'd1;

    always_comb begin
        n_state   = r_state;
        push_en   = 1'b0;
        push_byte = i_in.byte_value;
        start_pad = 1'b0;
        set_final = 1'b0;
        count_len = 1'b0;
        raddr     = r_cnt[2:0];
        we        = 1'b0;
        case (r_state)
            shamh_pkg::S_IDLE: begin
                if (in_fire) begin
                    push_en   = i_in.has_byte;
                    count_len = i_in.has_byte;
                    start_pad = i_in.is_last;
                    if (i_in.has_byte && r_slot == shamh_pkg::SLOT_LAST) begin
                        n_state = shamh_pkg::S_LOAD;
                    end else if (i_in.is_last) begin
                        n_state = shamh_pkg::S_PAD;
                    end
                end
            end
            shamh_pkg::S_PAD: begin
                push_en = 1'b1;
                if (!r_marked) begin
                    push_byte = shamh_pkg::PAD_MARK;
                end else if (r_len_ok && r_slot >= shamh_pkg::SLOT_LEN) begin
                    push_byte = len_byte;
                end else begin
                    push_byte = 8'h00;
                end
                if (r_slot == shamh_pkg::SLOT_LAST) begin
                    n_state   = shamh_pkg::S_LOAD;
                    set_final = r_marked && r_len_ok;
                end
            end
            shamh_pkg::S_LOAD: begin
                raddr = ~r_cnt[2:0];
                if (r_cnt == 6'd8) begin
                    n_state = shamh_pkg::S_ROUND;
                end
            end
            shamh_pkg::S_ROUND: begin
                if (r_cnt == 6'd63) begin
                    n_state = shamh_pkg::S_FOLD;
                end
            end
            shamh_pkg::S_FOLD: begin
                we = (r_cnt != 6'd0) && !r_final;
                if (r_cnt == 6'd8) begin
                    if (r_final) begin
                        n_state = shamh_pkg::S_OUT;
                    end else if (r_padding) begin
                        n_state = shamh_pkg::S_PAD;
                    end else begin
                        n_state = shamh_pkg::S_IDLE;
                    end
                end
            end
            shamh_pkg::S_OUT: begin
                if (out_fire && r_oidx == 3'd7) begin
                    n_state = shamh_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = shamh_pkg::S_IDLE;
            end
        endcase
    end

    assign wrap = push_en && r_slot == shamh_pkg::SLOT_LAST;

    assign sched_ctrl.push        = push_en;
    assign sched_ctrl.word_done   = r_slot[1:0] == 2'b11;
    assign sched_ctrl.byte_val    = push_byte;
    assign sched_ctrl.round_shift = r_state == shamh_pkg::S_ROUND;

    assign i_in.ready        = r_state == shamh_pkg::S_IDLE;
    assign o_out.valid       = r_state == shamh_pkg::S_OUT;
    assign o_out.digest_word = r_vars[0];
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = r_oidx == 3'd7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shamh_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_slot      <= '0;
            r_bit_len   <= '0;
            r_chain_vld <= '0;
            r_marked    <= 1'b0;
            r_len_ok    <= 1'b0;
            r_padding   <= 1'b0;
            r_final     <= 1'b0;
            r_oidx      <= '0;
        end else begin
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else if (r_state == shamh_pkg::S_LOAD || r_state == shamh_pkg::S_ROUND
                         || r_state == shamh_pkg::S_FOLD) begin
                r_cnt <= r_cnt + 6'd1;
            end
            if (push_en) begin
                r_slot <= r_slot + 6'd1;
            end
            if (count_len) begin
                r_bit_len <= r_bit_len + shamh_pkg::LEN_BITS'(8);
            end
            if (start_pad) begin
                r_marked  <= 1'b0;
                r_len_ok  <= 1'b0;
                r_padding <= 1'b1;
            end else if (r_state == shamh_pkg::S_PAD) begin
                r_marked <= 1'b1;
                // Room for the length field once the mark sits before it,
                // or in the extra block that follows a late mark.
                if ((!r_marked && r_slot < shamh_pkg::SLOT_LEN) || wrap) begin
                    r_len_ok <= 1'b1;
                end
            end
            if (set_final) begin
                r_final <= 1'b1;
            end
            if (we) begin
                r_chain_vld[waddr] <= 1'b1;
            end
            if (r_state == shamh_pkg::S_FOLD && r_cnt == 6'd8 && r_final) begin
                r_chain_vld <= '0;
                r_bit_len   <= '0;
                r_padding   <= 1'b0;
                r_final     <= 1'b0;
                r_oidx      <= '0;
            end
            if (out_fire) begin
                r_oidx <= r_oidx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= raddr;
        r_rd_iv   <= !r_chain_vld[raddr];
        case (r_state)
            shamh_pkg::S_LOAD: begin
                // Words arrive h first, so after eight shifts a sits at index 0.
                if (r_cnt != 6'd0) begin
                    r_vars[0] <= rd_word;
                    for (int i = 1; i < 8; i++) begin
                        r_vars[i] <= r_vars[i-1];
                    end
                end
            end
            shamh_pkg::S_ROUND: begin
                r_vars <= round_vars;
            end
            shamh_pkg::S_FOLD: begin
                // The sums rotate in behind, leaving chain word 0 at index 0.
                if (r_cnt != 6'd0) begin
                    for (int i = 0; i < 7; i++) begin
                        r_vars[i] <= r_vars[i+1];
                    end
                    r_vars[7] <= fold_sum;
                end
            end
            shamh_pkg::S_OUT: begin
                if (out_fire) begin
                    for (int i = 0; i < 7; i++) begin
                        r_vars[i] <= r_vars[i+1];
                    end
                    r_vars[7] <= r_vars[0];
                end
            end
            default: begin
            end
        endcase
    end

    shamh_ram #(
        .WIDTH(shamh_pkg::WORD_BITS),
        .DEPTH(shamh_pkg::NUM_CHAIN)
    ) u_chain_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(fold_sum),
        .i_raddr(raddr),
        .o_rdata(ram_q)
    );

    shamh_sched u_sched (
        .i_clk (i_clk),
        .i_ctrl(sched_ctrl),
        .o_w   (w_cur)
    );

    shamh_round u_round (
        .i_vars(r_vars),
        .i_k   (shamh_pkg::ROUND_K[r_cnt]),
        .i_w   (w_cur),
        .o_vars(round_vars)
    );

    a_slot_zero_at_compress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == shamh_pkg::S_LOAD && r_cnt == 6'd0) |-> r_slot == 6'd0)
        else $error("compression started with a partly filled block");

    a_len_cleared_on_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> (r_bit_len == '0 && r_chain_vld == '0 && !r_padding))
        else $error("message state not cleared before digest output");

    a_digest_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == shamh_pkg::S_FOLD && n_state == shamh_pkg::S_OUT) |-> r_final)
        else $error("digest output without the length block");

    a_no_write_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we && r_state != shamh_pkg::S_FOLD) |-> 1'b0)
        else $error("chain RAM written outside the fold step");

endmodule

`default_nettype wire

// ===== verif/sha256_message_hasher_tb.sv =====
`timescale 1ns / 1ps

module sha256_message_hasher_tb;

    typedef struct packed {
        logic [7:0] b;
        logic       has;
        logic       fin;
    } msg_xfer_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  pos;
        logic        fin;
    } digest_word_t;

    localparam logic [63:0] LEN_MASK = (shamh_pkg::LEN_BITS >= 64) ? {64{1'b1}} :
        ((64'd1 << shamh_pkg::LEN_BITS) - 64'd1);

    localparam logic [0:7][31:0] IV_TAB = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] K_TAB = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    shamh_in_if  in_if ();
    shamh_out_if out_if ();

    sha256_message_hasher i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    msg_xfer_t    pending_bytes [$];
    digest_word_t digests_due [$];
    int           items_queued;
    int           messages_queued;
    int           errors;
    int           pad_lens [6] = '{55, 56, 57, 63, 64, 65};

    // Hash state of the predictor.
    logic [31:0] hv [8];
    logic [31:0] blk [16];
    logic [63:0] msg_bits;
    logic [5:0]  fill;

    logic in_taken;
    logic out_taken;
    int   in_wait;
    int   out_wait;
    int   in_calm;
    int   out_calm;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function automatic void put_msg_byte(input int slot, input logic [7:0] b);
        int idx;
        int sh;
        idx = slot / 4;
        sh  = (3 - slot % 4) * 8;
        if (slot % 4 == 0)
            blk[idx] = 32'd0;
        blk[idx] = blk[idx] | ({24'd0, b} << sh);
    endfunction

    function automatic void compress_block();
        logic [31:0] v [8];
        logic [31:0] x15, x2, t1, t2;
        for (int i = 0; i < 8; i++)
            v[i] = hv[i];
        for (int t = 0; t < 64; t++) begin
            // The schedule rolls in place through the 16-word buffer.
            if (t >= 16) begin
                x15 = blk[(t + 1) % 16];
                x2  = blk[(t + 14) % 16];
                blk[t % 16] = blk[t % 16]
                    + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3))
                    + blk[(t + 9) % 16]
                    + (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10));
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + blk[t % 16];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hv[i] = hv[i] + v[i];
    endfunction

    function automatic void hash_step(input logic [7:0] b, input logic has, input logic fin);
        int           slot;
        logic [63:0]  len;
        digest_word_t dw;
        if (has) begin
            put_msg_byte(int'(fill), b);
            msg_bits = (msg_bits + 64'd8) & LEN_MASK;
            fill = fill + 6'd1;
            if (fill == 6'd0)
                compress_block();
        end
        if (!fin)
            return;
        slot = int'(fill);
        put_msg_byte(slot, 8'h80);
        slot++;
        // No room for the length field: pad out this block and start another.
        if (slot > 56) begin
            while (slot < 64) begin
                put_msg_byte(slot, 8'h00);
                slot++;
            end
            compress_block();
            slot = 0;
        end
        while (slot < 56) begin
            put_msg_byte(slot, 8'h00);
            slot++;
        end
        len = msg_bits & LEN_MASK;
        blk[14] = len[63:32];
        blk[15] = len[31:0];
        compress_block();
        for (int k = 0; k < 8; k++) begin
            dw.word = hv[k];
            dw.pos  = 3'(k);
            dw.fin  = (k == 7);
            digests_due.push_back(dw);
        end
        for (int i = 0; i < 8; i++)
            hv[i] = IV_TAB[i];
        msg_bits = 64'd0;
        fill     = 6'd0;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s: got %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic check_word(input logic [31:0] word, input logic [2:0] pos, input logic fin);
        digest_word_t dw;
        if (digests_due.size() == 0) begin
            report_mismatch("digest word with none outstanding", word, 0);
        end else begin
            dw = digests_due.pop_front();
            if (word !== dw.word)
                report_mismatch("digest_word", word, dw.word);
            if (pos !== dw.pos)
                report_mismatch("word_index", pos, dw.pos);
            if (fin !== dw.fin)
                report_mismatch("last_word", fin, dw.fin);
        end
    endtask

    // Mostly uniform waits, with occasional runs of back-to-back transfers.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 11);
    endfunction

    task automatic queue_item(input logic [7:0] b, input logic has, input logic fin);
        msg_xfer_t x;
        x.b   = b;
        x.has = has;
        x.fin = fin;
        pending_bytes.push_back(x);
        if (has || fin)
            items_queued++;
    endtask

    task automatic queue_message(input int n, input bit end_apart);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            queue_item(8'($urandom_range(0, 255)), 1'b1, (i == n - 1) && !end_apart);
        end
        if (end_apart || n == 0)
            queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        messages_queued++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
            for (int i = 0; i < 8; i++)
                hv[i] = IV_TAB[i];
            msg_bits = 64'd0;
            fill     = 6'd0;
        end else begin
            in_taken  <= in_if.valid && in_if.ready;
            out_taken <= out_if.valid && out_if.ready;
            if (in_if.valid && in_if.ready)
                hash_step(in_if.byte_value, in_if.has_byte, in_if.is_last);
            if (out_if.valid && out_if.ready)
                check_word(out_if.digest_word, out_if.word_index, out_if.last_word);
        end
    end

    always @(negedge i_clk) begin
        msg_xfer_t x;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (in_taken)
                in_wait = draw_wait(in_calm);
            if (in_wait > 0 || pending_bytes.size() == 0) begin
                in_if.valid <= 1'b0;
                if (in_wait > 0)
                    in_wait--;
            end else begin
                x = pending_bytes.pop_front();
                in_if.valid      <= 1'b1;
                in_if.byte_value <= x.b;
                in_if.has_byte   <= x.has;
                in_if.is_last    <= x.fin;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_taken)
                out_wait = draw_wait(out_calm);
            if (out_wait > 0) begin
                out_wait--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int len;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.byte_value = 8'h00;
        in_if.has_byte   = 1'b0;
        in_if.is_last    = 1'b0;
        out_if.ready     = 1'b0;
        in_wait          = 0;
        out_wait         = 0;
        in_calm          = 0;
        out_calm         = 0;
        errors           = 0;
        items_queued     = 0;
        messages_queued  = 0;

        // Directed: idle steps, the empty message, single-byte extremes, and a
        // short message closed by a transfer that carries no byte.
        queue_item(8'h00, 1'b0, 1'b0);
        queue_item(8'h00, 1'b0, 1'b1);
        queue_item(8'hff, 1'b0, 1'b0);
        queue_item(8'h00, 1'b1, 1'b1);
        queue_item(8'hff, 1'b1, 1'b1);
        queue_item(8'h61, 1'b1, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0);
        queue_item(8'h63, 1'b1, 1'b0);
        queue_item(8'hff, 1'b0, 1'b1);
        queue_item(8'haa, 1'b1, 1'b0);
        queue_item(8'h55, 1'b1, 1'b1);
        queue_item(8'h61, 1'b1, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1);
        queue_item(8'h00, 1'b0, 1'b1);
        messages_queued = 7;

        // Random messages, with lengths weighted toward the padding boundaries.
        while (items_queued < 300 || messages_queued < 14) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: len = $urandom_range(0, 8);
                4, 5, 6:    len = pad_lens[$urandom_range(0, 5)];
                7:          len = $urandom_range(9, 70);
                8:          len = ($urandom_range(0, 3) == 0) ? 128 : $urandom_range(110, 130);
                default:    len = 1;
            endcase
            queue_message(len, $urandom_range(0, 3) == 0);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || in_if.valid)
            @(posedge i_clk);
        while (digests_due.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/shamh_pkg.sv
rtl/shamh_in_if.sv
rtl/shamh_out_if.sv
rtl/shamh_ram.sv
rtl/shamh_sched.sv
rtl/shamh_round.sv
rtl/sha256_message_hasher.sv
verif/sha256_message_hasher_tb.sv
